// ===== sv/pfba_pkg.sv =====
// Package with the shared constants and the command/status types of the page frame allocator.
`timescale 1ns / 1ps
package pfba_pkg;

  localparam int NumFrames   = 4096;
  localparam int WordBits    = 64;
  localparam int MapWords    = NumFrames / WordBits;
  localparam int FrameW      = 12;
  localparam int LimitW      = 13;
  localparam int CountW      = 24;
  localparam int CntW        = 32;
  localparam int WordIdxW    = 6;
  localparam int BitIdxW     = 6;
  localparam int InDataW     = 40;
  localparam int OutDataW    = 112;

  localparam logic [1:0] OpAlloc    = 2'd0;
  localparam logic [1:0] OpFree     = 2'd1;
  localparam logic [1:0] OpUsable   = 2'd2;
  localparam logic [1:0] OpReserved = 2'd3;

  localparam logic [LimitW-1:0] LimitMax = LimitW'(NumFrames);

  typedef struct packed {
    logic load;
    logic srch_init;
    logic srch_restart;
    logic rd;
    logic eval;
    logic rmw_init;
    logic wr;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic is_alloc;
    logic is_reserved;
    logic cnt_zero;
    logic from_ok;
    logic hit;
    logic word_last;
    logic rmw_last;
    logic pass2;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== sv/pfba_map.sv =====
// Used-bit map memory, one word per entry, with per-word valid bits that read as all used.
`timescale 1ns / 1ps
module pfba_map import pfba_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rd_en_i,
  input  logic [WordIdxW-1:0] rd_addr_i,
  output logic [WordBits-1:0] rd_data_o,
  input  logic                wr_en_i,
  input  logic [WordIdxW-1:0] wr_addr_i,
  input  logic [WordBits-1:0] wr_data_i
);

  logic [WordBits-1:0] mem [MapWords];
  logic [MapWords-1:0] valid_q;
  logic [WordBits-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en_i) begin
      valid_q[wr_addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= valid_q[rd_addr_i] ? mem[rd_addr_i] : '1;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== sv/pfba_datapath.sv =====
// Datapath: item registers, word search, run marking and clearing, counters and result register.
`timescale 1ns / 1ps
module pfba_datapath import pfba_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dp_cmd_t             cmd_i,
  output dp_stat_t            stat_o,
  input  logic [InDataW-1:0]  in_data_i,
  input  logic [LimitW-1:0]   frame_limit_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [OutDataW-1:0] out_data_o
);

  logic [1:0]          op_q;
  logic [FrameW-1:0]   start_q;
  logic [CountW-1:0]   cnt_q;
  logic [LimitW-1:0]   lim_q;
  logic [LimitW-1:0]   from_q;
  logic [WordIdxW-1:0] w_q;
  logic [LimitW-1:0]   run_q;
  logic                pass2_q;
  logic                ok_q;
  logic [FrameW-1:0]   at_q;
  logic [LimitW-1:0]   lo_q;
  logic [LimitW-1:0]   hi_q;
  logic [FrameW-1:0]   srch_start_q;
  logic [CntW-1:0]     free_q;
  logic [CntW-1:0]     used_q;
  logic [CntW-1:0]     total_q;
  logic                out_valid_q;
  logic                out_status_q;
  logic [FrameW-1:0]   out_index_q;

  logic [WordBits-1:0] rd_data;
  logic [WordBits-1:0] wr_data;
  logic [LimitW-1:0]   base;
  logic [LimitW-1:0]   next_base;
  logic [WordBits-1:0] fr;
  logic [WordBits-1:0] hmask;
  logic [LimitW-1:0]   tot [WordBits];
  logic                hit;
  logic [LimitW-1:0]   hit_start;
  logic [CountW:0]     free_end;
  logic [LimitW-1:0]   clr_hi;
  logic [CntW-1:0]     cnt32;

  pfba_map u_map (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (cmd_i.rd),
    .rd_addr_i(w_q),
    .rd_data_o(rd_data),
    .wr_en_i  (cmd_i.wr),
    .wr_addr_i(w_q),
    .wr_data_i(wr_data)
  );

  assign base      = {1'b0, w_q, BitIdxW'(0)};
  assign next_base = ({1'b0, w_q} + LimitW'(1)) << BitIdxW;
  assign cnt32     = CntW'(cnt_q);
  assign free_end  = (CountW+1)'(start_q) + (CountW+1)'(cnt_q);
  assign clr_hi    = (free_end > (CountW+1)'(NumFrames)) ? LimitMax : free_end[LimitW-1:0];

  // Run length ending at each bit, carrying in the run from earlier words.
  always_comb begin
    logic [LimitW-1:0] idx;
    logic [LimitW-1:0] ones;
    logic              all;
    for (int b = 0; b < WordBits; b++) begin
      idx   = base + LimitW'(b);
      fr[b] = !rd_data[b] && (idx >= from_q) && (idx < lim_q);
    end
    for (int p = 0; p < WordBits; p++) begin
      ones = LimitW'(p + 1);
      all  = 1'b1;
      for (int j = 0; j <= p; j++) begin
        if (!fr[j]) begin
          ones = LimitW'(p - j);
          all  = 1'b0;
        end
      end
      tot[p] = all ? run_q + LimitW'(p + 1) : ones;
    end
    hit       = 1'b0;
    hit_start = '0;
    for (int p = WordBits - 1; p >= 0; p--) begin
      if (CountW'(tot[p]) >= cnt_q) begin
        hit       = 1'b1;
        hit_start = base + LimitW'(p + 1) - tot[p];
      end
    end
  end

  always_comb begin
    logic [LimitW-1:0] idx;
    for (int b = 0; b < WordBits; b++) begin
      idx      = base + LimitW'(b);
      hmask[b] = (idx >= lo_q) && (idx < hi_q);
    end
    wr_data = (op_q == OpAlloc) ? (rd_data | hmask) : (rd_data & ~hmask);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= in_data_i[1:0];
      start_q <= in_data_i[2 +: FrameW];
      cnt_q   <= in_data_i[2 + FrameW +: CountW];
      lim_q   <= (frame_limit_i > LimitMax) ? LimitMax : frame_limit_i;
      ok_q    <= 1'b0;
    end
    if (cmd_i.srch_init) begin
      from_q  <= {1'b0, srch_start_q};
      w_q     <= srch_start_q[FrameW-1 -: WordIdxW];
      run_q   <= '0;
      pass2_q <= 1'b0;
    end
    if (cmd_i.srch_restart) begin
      from_q  <= '0;
      w_q     <= '0;
      run_q   <= '0;
      pass2_q <= 1'b1;
    end
    if (cmd_i.eval) begin
      if (hit) begin
        ok_q <= 1'b1;
        at_q <= hit_start[FrameW-1:0];
        lo_q <= hit_start;
        hi_q <= hit_start + cnt_q[LimitW-1:0];
        w_q  <= hit_start[FrameW-1 -: WordIdxW];
      end else begin
        run_q <= tot[WordBits-1];
        w_q   <= w_q + WordIdxW'(1);
      end
    end
    if (cmd_i.rmw_init) begin
      lo_q <= {1'b0, start_q};
      hi_q <= clr_hi;
      w_q  <= start_q[FrameW-1 -: WordIdxW];
    end
    if (cmd_i.wr) begin
      w_q <= w_q + WordIdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      srch_start_q <= '0;
      free_q       <= '0;
      used_q       <= '0;
      total_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
        unique case (op_q)
          OpAlloc: begin
            if (ok_q) begin
              srch_start_q <= at_q;
              used_q       <= used_q + cnt32;
              free_q       <= free_q - cnt32;
            end
          end
          OpFree: begin
            used_q <= used_q - cnt32;
            free_q <= free_q + cnt32;
          end
          OpUsable: begin
            total_q <= total_q + cnt32;
            free_q  <= free_q + cnt32;
          end
          default: begin
            total_q <= total_q + cnt32;
            used_q  <= used_q + cnt32;
          end
        endcase
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_status_q <= (op_q == OpAlloc) && !ok_q;
      out_index_q  <= ((op_q == OpAlloc) && ok_q) ? at_q : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {3'b000, total_q, used_q, free_q, out_index_q, out_status_q};

  assign stat_o.is_alloc    = (op_q == OpAlloc);
  assign stat_o.is_reserved = (op_q == OpReserved);
  assign stat_o.cnt_zero    = (cnt_q == '0);
  assign stat_o.from_ok     = (from_q < lim_q);
  assign stat_o.hit         = hit;
  assign stat_o.word_last   = (next_base >= lim_q);
  assign stat_o.rmw_last    = (next_base >= hi_q);
  assign stat_o.pass2       = pass2_q;
  assign stat_o.out_free    = !out_valid_q || out_ready_i;

endmodule

// ===== sv/pfba_ctrl.sv =====
// Controller state machine sequencing search passes, map updates and result hand-off.
`timescale 1ns / 1ps
module pfba_ctrl import pfba_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StDec  = 3'd1;
  localparam logic [2:0] StChk  = 3'd2;
  localparam logic [2:0] StSrd  = 3'd3;
  localparam logic [2:0] StSev  = 3'd4;
  localparam logic [2:0] StMrd  = 3'd5;
  localparam logic [2:0] StMwr  = 3'd6;
  localparam logic [2:0] StDone = 3'd7;

  logic [2:0] state_q;
  logic [2:0] state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StDec;
        end
      end
      StDec: begin
        if (stat_i.is_reserved || stat_i.cnt_zero) begin
          state_d = StDone;
        end else if (stat_i.is_alloc) begin
          cmd_o.srch_init = 1'b1;
          state_d         = StChk;
        end else begin
          cmd_o.rmw_init = 1'b1;
          state_d        = StMrd;
        end
      end
      StChk: begin
        if (stat_i.from_ok) begin
          state_d = StSrd;
        end else if (!stat_i.pass2) begin
          cmd_o.srch_restart = 1'b1;
        end else begin
          state_d = StDone;
        end
      end
      StSrd: begin
        cmd_o.rd = 1'b1;
        state_d  = StSev;
      end
      StSev: begin
        if (stat_i.hit) begin
          cmd_o.eval = 1'b1;
          state_d    = StMrd;
        end else if (!stat_i.word_last) begin
          cmd_o.eval = 1'b1;
          state_d    = StSrd;
        end else if (!stat_i.pass2) begin
          cmd_o.srch_restart = 1'b1;
          state_d            = StChk;
        end else begin
          state_d = StDone;
        end
      end
      StMrd: begin
        cmd_o.rd = 1'b1;
        state_d  = StMwr;
      end
      StMwr: begin
        cmd_o.wr = 1'b1;
        state_d  = stat_i.rmw_last ? StDone : StMrd;
      end
      StDone: begin
        if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/page_frame_bitmap_allocator.sv =====
// Top level of the bitmap page frame allocator.
`timescale 1ns / 1ps
// One item is handled at a time. Free and add-usable read and rewrite each
// 64-frame map word touched; add-reserved and zero counts skip the map.
// Alloc walks the map word by word, a read then an evaluation, from the word
// of the last run handed out up to frame_limit, then once more from frame 0
// if that fails, then marks the run with a read and a write per word, each
// read going through the registered read port of the used-bit memory. The map
// starts all used after reset, with no clearing pass. A result waits in an
// output register.
module page_frame_bitmap_allocator import pfba_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // [1:0] op, [13:2] start_frame, [37:14] count
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // [0] status, [12:1] frame_index, [44:13] free_pages, [76:45] used_pages,
  // [108:77] total_pages
  output logic [OutDataW-1:0] m_axis_tdata_o,
  input  logic                cfg_we_i,
  input  logic [LimitW-1:0]   cfg_wdata_i
);

  logic [LimitW-1:0] frame_limit_q;
  dp_cmd_t           cmd;
  dp_stat_t          stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_limit_q <= LimitMax;
    end else if (cfg_we_i) begin
      frame_limit_q <= cfg_wdata_i;
    end
  end

  pfba_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid_i),
    .in_ready_o(s_axis_tready_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  pfba_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .in_data_i    (s_axis_tdata_i),
    .frame_limit_i(frame_limit_q),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_data_o   (m_axis_tdata_o)
  );

endmodule

// ===== sv/pfba_checker.sv =====
// Port-level checker for the page frame allocator, bound to the top level.
`timescale 1ns / 1ps
module pfba_checker import pfba_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid_i,
  input logic                s_axis_tready_o,
  input logic                m_axis_tvalid_o,
  input logic                m_axis_tready_i,
  input logic [OutDataW-1:0] m_axis_tdata_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result item changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input accepted while an item is in work");

  a_fail_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[0] |-> m_axis_tdata_o[FrameW:1] == '0)
    else $error("failed alloc reports a nonzero frame index");

  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(!s_axis_tready_o))
    else $error("result item appeared with no item in work");

endmodule

bind page_frame_bitmap_allocator pfba_checker u_pfba_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_o(s_axis_tready_o),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench for the bitmap page frame allocator.
`timescale 1ns / 1ps
module tb_top;
  import pfba_pkg::*;

  localparam int CycleLimit = 3000000;

  typedef struct packed {
    logic [CntW-1:0]   total;
    logic [CntW-1:0]   used;
    logic [CntW-1:0]   free;
    logic [FrameW-1:0] idx;
    logic              st;
  } pfa_res_t;

  typedef struct {
    logic [FrameW-1:0] at;
    int unsigned       len;
  } run_t;

  logic                clk_i = 0;
  logic                rst_ni = 0;
  logic                s_axis_tvalid_i = 0;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i = '0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 0;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic                cfg_we_i = 0;
  logic [LimitW-1:0]   cfg_wdata_i = '0;

  page_frame_bitmap_allocator dut (.*);

  // predictor state
  logic [NumFrames-1:0] map_used;
  logic [FrameW-1:0]    next_fit;
  logic [CntW-1:0]      free_cnt, used_cnt, total_cnt;
  logic [LimitW-1:0]    limit_reg;

  pfa_res_t    pending_res[$];
  run_t        live_runs[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned hold_off = 0;
  int unsigned alloc_ok = 0;

  initial forever #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic bit find_free_run(int unsigned from, int unsigned lim,
                                       int unsigned need, output int unsigned at);
    int unsigned run;
    int unsigned first;
    run = 0;
    first = 0;
    at = 0;
    for (int unsigned i = from; i < lim; i++) begin
      if (!map_used[i]) begin
        if (run == 0) first = i;
        run++;
        if (run >= need) begin
          at = first;
          return 1;
        end
      end else begin
        run = 0;
      end
    end
    return 0;
  endfunction

  function automatic void clear_frames(int unsigned start, int unsigned cnt);
    longint unsigned stop;
    stop = longint'(start) + cnt;
    if (stop > NumFrames) stop = NumFrames;
    for (longint unsigned i = start; i < stop; i++) map_used[i] = 1'b0;
  endfunction

  function automatic pfa_res_t predict_alloc(logic [1:0] op, logic [FrameW-1:0] start,
                                             logic [CountW-1:0] cnt);
    pfa_res_t    r;
    int unsigned lim;
    int unsigned at;
    bit          ok;
    r = '0;
    ok = 0;
    at = 0;
    case (op)
      OpAlloc: begin
        lim = (limit_reg > NumFrames) ? NumFrames : limit_reg;
        if (cnt != 0) begin
          ok = find_free_run(next_fit, lim, cnt, at);
          if (!ok) ok = find_free_run(0, lim, cnt, at);
        end
        if (ok) begin
          for (int unsigned i = 0; i < cnt; i++) map_used[(at + i) % NumFrames] = 1'b1;
          next_fit = FrameW'(at);
          used_cnt += cnt;
          free_cnt -= cnt;
          r.idx = FrameW'(at);
          alloc_ok++;
          live_runs.push_back('{at: FrameW'(at), len: cnt});
        end else begin
          r.st = 1'b1;
        end
      end
      OpFree: begin
        clear_frames(start, cnt);
        used_cnt -= cnt;
        free_cnt += cnt;
      end
      OpUsable: begin
        clear_frames(start, cnt);
        total_cnt += cnt;
        free_cnt += cnt;
      end
      default: begin
        total_cnt += cnt;
        used_cnt += cnt;
      end
    endcase
    r.free = free_cnt;
    r.used = used_cnt;
    r.total = total_cnt;
    return r;
  endfunction

  function automatic int unsigned rand_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_item(logic [1:0] op, logic [FrameW-1:0] start, logic [CountW-1:0] cnt,
                           bit no_gap = 0);
    int unsigned gap;
    gap = no_gap ? 0 : rand_gap();
    if (gap > 0) begin
      s_axis_tvalid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata_i = {2'b00, cnt, start, op};
    s_axis_tvalid_i = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_res.push_back(predict_alloc(op, start, cnt));
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    s_axis_tvalid_i = 1'b0;
    while (pending_res.size() != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
  endtask

  task automatic write_limit(logic [LimitW-1:0] v);
    wait_idle();
    cfg_wdata_i = v;
    cfg_we_i = 1'b1;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    limit_reg = v;
  endtask

  // receiver ready, with random stalls and an optional long hold-off
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_off > 0) begin
        m_axis_tready_i = 1'b0;
        hold_off--;
      end else begin
        m_axis_tready_i = ($urandom_range(0, 99) < 70) || (rand_gap() == 0);
      end
    end
  end

  always @(posedge clk_i) begin
    pfa_res_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o[$bits(pfa_res_t)-1:0];
      if (pending_res.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected item: %h", got);
      end else begin
        want = pending_res.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display({"mismatch: exp st=%0d idx=%0d free=%0d used=%0d total=%0d",
                      " | act st=%0d idx=%0d free=%0d used=%0d total=%0d"},
                     want.st, want.idx, want.free, want.used, want.total,
                     got.st, got.idx, got.free, got.used, got.total);
        end
      end
    end
  end

  task automatic test_directed();
    send_item(OpAlloc, 0, 1);                 // nothing usable yet
    send_item(OpAlloc, 0, 0);                 // zero count
    send_item(OpUsable, 0, 256);
    send_item(OpAlloc, 12'hfff, 1);           // run at frame zero
    send_item(OpAlloc, 0, 64);
    send_item(OpAlloc, 0, 0);
    send_item(OpFree, 0, 1);
    send_item(OpReserved, 12'hfff, 24'hffffff);
    send_item(OpUsable, 4000, 200);           // run past the map
    send_item(OpFree, 12'hfff, 24'hffffff);
    send_item(OpAlloc, 0, 4096);
    send_item(OpUsable, 0, 4096);
    send_item(OpAlloc, 0, 4096);
    send_item(OpFree, 0, 4096);
    send_item(OpAlloc, 0, 24'hffffff);
    send_item(OpAlloc, 0, 8);
    send_item(OpAlloc, 0, 4000);
    write_limit(0);
    send_item(OpAlloc, 0, 1);
    write_limit(LimitMax);
    send_item(OpAlloc, 0, 32);                // next fit continues past last run
    write_limit(13'h1fff);
    send_item(OpAlloc, 0, 16);
    write_limit(100);                         // next-fit start past the limit
    send_item(OpAlloc, 0, 4);
    write_limit(1);
    send_item(OpAlloc, 0, 1);
    live_runs.delete();
  endtask

  task automatic random_item();
    int unsigned p;
    run_t        r;
    logic [CountW-1:0] c;
    p = $urandom_range(0, 99);
    c = CountW'(($urandom_range(0, 9) < 8) ? $urandom_range(1, 80) :
        (($urandom_range(0, 1) != 0) ? $urandom_range(0, 4200) : $urandom()));
    if (p < 45) begin
      send_item(OpAlloc, FrameW'($urandom()), c);
    end else if (p < 75) begin
      if (live_runs.size() != 0 && $urandom_range(0, 3) != 0) begin
        r = live_runs[$urandom_range(0, live_runs.size() - 1)];
        send_item(OpFree, r.at, CountW'(r.len));
      end else begin
        send_item(OpFree, FrameW'($urandom()), c);
      end
    end else if (p < 90) begin
      send_item(OpUsable, FrameW'($urandom()), c);
    end else begin
      send_item(OpReserved, FrameW'($urandom()), c);
    end
    if (live_runs.size() > 64) void'(live_runs.pop_front());
  endtask

  task automatic test_random(int unsigned n);
    repeat (n) random_item();
  endtask

  task automatic test_backpressure();
    wait_idle();
    hold_off = 400;
    repeat (20) send_item(OpReserved, FrameW'($urandom()), CountW'($urandom_range(0, 15)), 1);
  endtask

  initial begin
    map_used = '1;
    next_fit = '0;
    free_cnt = '0;
    used_cnt = '0;
    total_cnt = '0;
    limit_reg = LimitMax;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    write_limit(LimitMax);
    test_random(400);
    test_backpressure();
    write_limit(LimitW'($urandom_range(64, 4095)));
    test_random(250);
    write_limit(13'h1fff);
    test_random(250);
    write_limit(0);
    test_random(30);
    write_limit(LimitMax);
    test_random(270);
    wait_idle();
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== page_frame_bitmap_allocator.f =====
sv/pfba_pkg.sv
sv/pfba_map.sv
sv/pfba_datapath.sv
sv/pfba_ctrl.sv
sv/page_frame_bitmap_allocator.sv
sv/pfba_checker.sv
tb/tb_top.sv
